FILE: src/mncp_pkg.sv
// Shared types and codes for the MIDI note and control-change parser.
// No dependencies; imported by mncp_parser, midi_note_cc_parser and the testbench.

package mncp_pkg;

    // Parse position within a three-byte message.
    typedef enum logic [2:0] {
        PH_WAIT_STATUS = 3'd0,
        PH_NOTE_D1     = 3'd1,
        PH_NOTE_D2     = 3'd2,
        PH_CC_D1       = 3'd3,
        PH_CC_D2       = 3'd4
    } phase_t;

    // Kind of the last completed message, used for running status.
    typedef enum logic [1:0] {
        LK_NONE = 2'd0,
        LK_NOTE = 2'd1,
        LK_CC   = 2'd2
    } last_kind_t;

    // Result kind codes.
    localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_CC       = 2'd2;

    // Upper nibbles of the status bytes that start a message.
    localparam logic [3:0] HI_NOTE_OFF = 4'h8;
    localparam logic [3:0] HI_NOTE_ON  = 4'h9;
    localparam logic [3:0] HI_CC       = 4'hB;

    localparam int unsigned RESULT_BITS = 30;
    localparam int unsigned TDATA_BITS  = 32;

    // One completed message.
    typedef struct packed {
        logic [7:0] second_data;
        logic [7:0] first_data;
        logic [7:0] status_byte;
        logic [3:0] msg_channel;
        logic [1:0] msg_kind;
    } msg_t;

    // Parser result for one processed byte.
    typedef struct packed {
        logic emit;
        msg_t msg;
    } parse_out_t;

endpackage

FILE: src/mncp_parser.sv
// Parse state machine: one MIDI byte per enabled cycle, running status.
// Depends on mncp_pkg.

module mncp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [7:0]          in_byte,
    output mncp_pkg::parse_out_t result
);
    import mncp_pkg::*;

    phase_t     phase_reg, phase_next;
    last_kind_t last_kind_reg, last_kind_next;
    phase_t     eff_phase;

    // Kept headers; channel and note-on flag come from the status byte.
    logic [7:0] note_status_reg, note_status_next;
    logic [7:0] note_number_reg, note_number_next;
    logic [7:0] cc_status_reg, cc_status_next;
    logic [7:0] cc_number_reg, cc_number_next;

    logic [3:0] hi;
    assign hi = in_byte[7:4];

    // A data byte while waiting for status restarts the last kind.
    always_comb begin
        unique case (phase_reg)
            PH_NOTE_D1, PH_NOTE_D2, PH_CC_D1, PH_CC_D2: eff_phase = phase_reg;
            default: begin
                eff_phase = PH_WAIT_STATUS;
                if (!in_byte[7]) begin
                    if (last_kind_reg == LK_NOTE) begin
                        eff_phase = PH_NOTE_D1;
                    end else if (last_kind_reg == LK_CC) begin
                        eff_phase = PH_CC_D1;
                    end
                end
            end
        endcase
    end

    // Next state.
    always_comb begin
        phase_next     = PH_WAIT_STATUS;
        last_kind_next = last_kind_reg;
        unique case (eff_phase)
            PH_NOTE_D1: phase_next = PH_NOTE_D2;
            PH_NOTE_D2: last_kind_next = LK_NOTE;
            PH_CC_D1:   phase_next = PH_CC_D2;
            PH_CC_D2:   last_kind_next = LK_CC;
            default: begin
                if (hi == HI_NOTE_ON || hi == HI_NOTE_OFF) begin
                    phase_next = PH_NOTE_D1;
                end else if (hi == HI_CC) begin
                    phase_next = PH_CC_D1;
                end
            end
        endcase
    end

    // Outputs and header updates.
    always_comb begin
        note_status_next = note_status_reg;
        note_number_next = note_number_reg;
        cc_status_next   = cc_status_reg;
        cc_number_next   = cc_number_reg;
        result.emit      = 1'b0;
        result.msg.msg_kind    = note_status_reg[4] ? KIND_NOTE_ON : KIND_NOTE_OFF;
        result.msg.msg_channel = note_status_reg[3:0];
        result.msg.status_byte = note_status_reg;
        result.msg.first_data  = note_number_reg;
        result.msg.second_data = in_byte;
        unique case (eff_phase)
            PH_NOTE_D1: note_number_next = in_byte;
            PH_NOTE_D2: result.emit = 1'b1;
            PH_CC_D1:   cc_number_next = in_byte;
            PH_CC_D2: begin
                result.emit            = 1'b1;
                result.msg.msg_kind    = KIND_CC;
                result.msg.msg_channel = cc_status_reg[3:0];
                result.msg.status_byte = cc_status_reg;
                result.msg.first_data  = cc_number_reg;
            end
            default: begin
                if (hi == HI_NOTE_ON || hi == HI_NOTE_OFF) begin
                    note_status_next = in_byte;
                end else if (hi == HI_CC) begin
                    cc_status_next = in_byte;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_WAIT_STATUS;
            last_kind_reg   <= LK_NONE;
            note_status_reg <= '0;
            note_number_reg <= '0;
            cc_status_reg   <= '0;
            cc_number_reg   <= '0;
        end else if (en) begin
            phase_reg       <= phase_next;
            last_kind_reg   <= last_kind_next;
            note_status_reg <= note_status_next;
            note_number_reg <= note_number_next;
            cc_status_reg   <= cc_status_next;
            cc_number_reg   <= cc_number_next;
        end
    end

endmodule

FILE: src/midi_note_cc_parser.sv
// Top level of the MIDI note-on, note-off and control-change parser.
// Depends on mncp_pkg and mncp_parser.
//
// Channel   Dir  Bits  Contents (lowest bit first)
// s_        in   8     in_byte
// m_        out  32    msg_kind, msg_channel, status_byte, first_data, second_data, pad
//
// Each byte passes from the input transfer into the input register, then the
// parse logic writes the result to the output register. One byte can be taken
// every cycle while the skid register is free; the parse state update sets the rate.
// Reset (aresetn low at a clock edge) clears the parse state and both queues.
// The output has a main register and a skid register, so a stalled result
// holds off input only once both are occupied.

module midi_note_cc_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [1:0] msg_kind, [5:2] msg_channel,
                                   // [13:6] status_byte, [21:14] first_data,
                                   // [29:22] second_data, [31:30] zero
);
    import mncp_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Output queue: main register drives the port, skid catches overflow.
    logic       main_valid_reg;
    msg_t       main_reg;
    logic       skid_valid_reg;
    msg_t       skid_reg;

    parse_out_t parsed;
    logic       proc;
    logic       push;
    logic       pop;
    logic       in_take;

    // The input byte is parsed whenever the skid register is free, so a
    // possible result always has a place to go.
    assign proc    = in_valid_reg && !skid_valid_reg;
    assign push    = proc && parsed.emit;
    assign pop     = main_valid_reg && m_tready;
    assign s_tready = !in_valid_reg || proc;
    assign in_take = s_tvalid && s_tready;

    mncp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (proc),
        .in_byte (in_byte_reg),
        .result  (parsed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_tdata;
        end
    end

    // Output queue control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || pop) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output queue data.
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_reg <= skid_reg;
                if (push) begin
                    skid_reg <= parsed.msg;
                end
            end else if (push) begin
                main_reg <= parsed.msg;
            end
        end else if (push) begin
            skid_reg <= parsed.msg;
        end
    end

    assign m_tvalid = main_valid_reg;
    assign m_tdata  = {{(TDATA_BITS - RESULT_BITS){1'b0}}, main_reg};

`ifndef ASSERT_OFF
    // The skid register only fills behind a waiting main register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid register occupied while main register empty");

    // A control-change result carries a 0xBn status byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == KIND_CC) |-> (m_tdata[13:10] == HI_CC))
        else $error("control-change result with wrong status byte");

    // A note result kind matches its status byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != KIND_CC) |->
            (m_tdata[13:11] == 3'b100 && m_tdata[1:0] == {1'b0, m_tdata[10]}))
        else $error("note result kind disagrees with status byte");

    // A result appears only after a parsed byte produced a message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_tvalid)) |-> $past(push))
        else $error("result appeared without a parsed message");
`endif

endmodule

FILE: tb/midi_note_cc_parser_tb.sv
// Self-checking testbench for midi_note_cc_parser: byte streams in, parsed messages out.
// Depends on mncp_pkg and the parser RTL; the expected messages come from a predictor
// inside the tracker class below.

module midi_note_cc_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mncp_pkg::*;

    // Total bytes offered; the last stretch of them runs without any idling.
    localparam int unsigned TOTAL_BYTES  = 1700;
    localparam int unsigned QUIET_BYTES  = 250;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Keeps its own copy of the parse state and the queue of messages that the
    // block still owes. take_byte is called for every input transfer and
    // check_msg for every result transfer.
    class midi_msg_tracker;
        phase_t     phase;
        last_kind_t last_done;
        bit         note_on;
        logic [3:0] note_chan;
        logic [7:0] note_stat;
        logic [7:0] note_num;
        logic [3:0] cc_chan;
        logic [7:0] cc_stat;
        logic [7:0] cc_num;
        msg_t       owed_msgs[$];
        int         mismatches;

        function new();
            phase      = PH_WAIT_STATUS;
            last_done  = LK_NONE;
            note_on    = 1'b0;
            note_chan  = '0;
            note_stat  = '0;
            note_num   = '0;
            cc_chan    = '0;
            cc_stat    = '0;
            cc_num     = '0;
            mismatches = 0;
        endfunction

        function void take_byte(logic [7:0] b);
            phase_t ph;
            msg_t   m;
            ph = phase;
            // A data byte while waiting for status reuses the header of the
            // last completed message kind (running status).
            if (ph == PH_WAIT_STATUS && !b[7]) begin
                if (last_done == LK_NOTE)
                    ph = PH_NOTE_D1;
                else if (last_done == LK_CC)
                    ph = PH_CC_D1;
            end
            case (ph)
                PH_NOTE_D1: begin
                    note_num = b;
                    phase    = PH_NOTE_D2;
                end
                PH_NOTE_D2: begin
                    m.msg_kind    = note_on ? KIND_NOTE_ON : KIND_NOTE_OFF;
                    m.msg_channel = note_chan;
                    m.status_byte = note_stat;
                    m.first_data  = note_num;
                    m.second_data = b;
                    owed_msgs.push_back(m);
                    phase     = PH_WAIT_STATUS;
                    last_done = LK_NOTE;
                end
                PH_CC_D1: begin
                    cc_num = b;
                    phase  = PH_CC_D2;
                end
                PH_CC_D2: begin
                    m.msg_kind    = KIND_CC;
                    m.msg_channel = cc_chan;
                    m.status_byte = cc_stat;
                    m.first_data  = cc_num;
                    m.second_data = b;
                    owed_msgs.push_back(m);
                    phase     = PH_WAIT_STATUS;
                    last_done = LK_CC;
                end
                default: begin
                    // Waiting for status: only note and cc status bytes start a
                    // message; everything else leaves the state alone.
                    phase = PH_WAIT_STATUS;
                    if (b[7:4] == HI_NOTE_ON || b[7:4] == HI_NOTE_OFF) begin
                        note_on   = (b[7:4] == HI_NOTE_ON);
                        note_chan = b[3:0];
                        note_stat = b;
                        phase     = PH_NOTE_D1;
                    end else if (b[7:4] == HI_CC) begin
                        cc_chan = b[3:0];
                        cc_stat = b;
                        phase   = PH_CC_D1;
                    end
                end
            endcase
        endfunction

        function void check_msg(logic [31:0] tdata);
            msg_t got;
            msg_t exp_msg;
            got = tdata[29:0];
            if (owed_msgs.size() == 0) begin
                $display("%0t: unexpected message, expected none, actual %h", $time, tdata);
                mismatches++;
                return;
            end
            exp_msg = owed_msgs.pop_front();
            if (got.msg_kind !== exp_msg.msg_kind) begin
                $display("%0t: msg_kind expected %0d actual %0d",
                         $time, exp_msg.msg_kind, got.msg_kind);
                mismatches++;
            end
            if (got.msg_channel !== exp_msg.msg_channel) begin
                $display("%0t: msg_channel expected %0d actual %0d",
                         $time, exp_msg.msg_channel, got.msg_channel);
                mismatches++;
            end
            if (got.status_byte !== exp_msg.status_byte) begin
                $display("%0t: status_byte expected %h actual %h",
                         $time, exp_msg.status_byte, got.status_byte);
                mismatches++;
            end
            if (got.first_data !== exp_msg.first_data) begin
                $display("%0t: first_data expected %h actual %h",
                         $time, exp_msg.first_data, got.first_data);
                mismatches++;
            end
            if (got.second_data !== exp_msg.second_data) begin
                $display("%0t: second_data expected %h actual %h",
                         $time, exp_msg.second_data, got.second_data);
                mismatches++;
            end
            if (tdata[31:30] !== 2'b00) begin
                $display("%0t: pad bits expected 0 actual %b", $time, tdata[31:30]);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // Set for the final stretch of the run, where neither side idles.
    bit          quiet    = 1'b0;
    int unsigned sent     = 0;

    midi_msg_tracker book = new();

    midi_note_cc_parser uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Generous cap: the slowest correct run is well under a tenth of this.
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Both channels are sampled at the clock edge. The result side is checked
    // first so that an input transfer in the same cycle cannot hide an unexpected
    // result; a byte passes the input register before its message is output anyway.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                book.check_msg(m_tdata);
            if (s_tvalid && s_tready)
                book.take_byte(s_tdata);
        end
    end

    // Result side: ready stays high for a random stretch, with occasional short
    // stalls until the quiet stretch begins.
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // Offers one byte, optionally after a short idle burst, and returns once the
    // transfer has happened. Valid stays high into the next call, so back-to-back
    // bytes go out without a gap.
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
        if (sent >= TOTAL_BYTES - QUIET_BYTES)
            quiet = 1'b1;
    endtask

    // Mostly a proper data byte; now and then any byte at all, so that status
    // values also land in data positions.
    function automatic logic [7:0] data_byte();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    // A note-off, note-on or cc status byte on a random channel.
    function automatic logic [7:0] msg_status();
        logic [3:0] chan;
        chan = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 2))
            0:       return {HI_NOTE_OFF, chan};
            1:       return {HI_NOTE_ON, chan};
            default: return {HI_CC, chan};
        endcase
    endfunction

    initial begin
        int unsigned pick;
        int unsigned cycles;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. A data byte right after reset has no history and must
        // be dropped; a system byte while waiting is ignored as well.
        send_byte(8'h45);
        send_byte(8'hF8);
        // Note-on, then running status reusing it with all-zero data.
        send_byte({HI_NOTE_ON, 4'h0});
        send_byte(8'h3C);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h00);
        // Note-off on the top channel.
        send_byte({HI_NOTE_OFF, 4'hF});
        send_byte(8'h7F);
        send_byte(8'h40);
        // Control change, an ignored status byte, then running status on the cc.
        send_byte({HI_CC, 4'h0});
        send_byte(8'h07);
        send_byte(8'h64);
        send_byte(8'hFE);
        send_byte(8'h01);
        send_byte(8'h7F);
        // Status bytes in data positions are taken as plain data.
        send_byte({HI_NOTE_ON, 4'hA});
        send_byte({HI_CC, 4'h3});
        send_byte(8'hFF);
        send_byte({HI_CC, 4'hF});
        send_byte(8'h80);
        send_byte(8'h00);

        // Random part: mostly complete messages and running-status pairs with
        // random content, some with arbitrary data bytes, and a little noise.
        while (sent < TOTAL_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_byte(msg_status());
                send_byte(8'($urandom_range(0, 127)));
                send_byte(8'($urandom_range(0, 127)));
            end else if (pick < 70) begin
                send_byte(data_byte());
                send_byte(data_byte());
            end else if (pick < 85) begin
                send_byte(msg_status());
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end else if (pick < 93) begin
                // Status bytes the parser does not handle, from 0xCn
                // to 0xFn.
                send_byte(8'($urandom_range(8'hC0, 8'hFF)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;

        // Wait until every owed message has come out, then a few more cycles in
        // case something unexpected is still on its way.
        cycles = 0;
        while (book.owed_msgs.size() != 0 && cycles < 10000) begin
            @(posedge aclk);
            cycles++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (book.owed_msgs.size() != 0)
            $display("%0t: %0d expected messages never arrived, oldest %h",
                     $time, book.owed_msgs.size(), book.owed_msgs[0]);
        if (book.mismatches == 0 && book.owed_msgs.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/mncp_pkg.sv
src/mncp_parser.sv
src/midi_note_cc_parser.sv
tb/midi_note_cc_parser_tb.sv
